@@ rtl/tmhs_pkg.sv @@
// ----------------------------------------------------------------------------
// tmhs_pkg
// shared constants, codes and types of the timer table scheduler
// ----------------------------------------------------------------------------
package tmhs_pkg;

    localparam int SLOTS   = 64;
    localparam int ID_W    = $clog2(SLOTS);
    localparam int CNT_W   = ID_W + 1;
    localparam int TIME_W  = 32;
    localparam int FIRE_W  = 8;
    localparam int WAIT_W  = 33;
    localparam int ST_W    = 3;

    localparam logic [1:0] ACT_ADD    = 2'd0;
    localparam logic [1:0] ACT_CANCEL = 2'd1;
    localparam logic [1:0] ACT_POLL   = 2'd2;

    localparam logic [ST_W-1:0] ST_DONE    = 3'd0;
    localparam logic [ST_W-1:0] ST_EXPIRED = 3'd1;
    localparam logic [ST_W-1:0] ST_NONE    = 3'd2;
    localparam logic [ST_W-1:0] ST_BUSY    = 3'd3;
    localparam logic [ST_W-1:0] ST_UNARMED = 3'd4;

    typedef struct packed {
        logic [TIME_W-1:0] expiry;
        logic [TIME_W-1:0] period;
        logic [FIRE_W-1:0] fires;
    } t_entry;

    typedef struct packed {
        logic load;
        logic exec;
        logic scan_start;
        logic scan_pick;
        logic pick_rd;
        logic pick_upd;
        logic emit_rd;
        logic emit_out;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic pick_mode;
        logic in_pick;
        logic found;
        logic out_free;
        logic emit_last;
    } t_sts;

endpackage

@@ rtl/tmhs_if.sv @@
// ----------------------------------------------------------------------------
// tmhs_if
// request and response channels of the timer table scheduler
// ----------------------------------------------------------------------------
interface tmhs_req_if
    import tmhs_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [1:0]        action;
    logic [ID_W-1:0]   timer_id;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] period;
    logic [FIRE_W-1:0] fire_count;

    modport source (output valid, action, timer_id, now, period, fire_count, input ready);
    modport sink   (input valid, action, timer_id, now, period, fire_count, output ready);
endinterface

interface tmhs_rsp_if
    import tmhs_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [ST_W-1:0]          status;
    logic [ID_W-1:0]          expired_id;
    logic signed [WAIT_W-1:0] next_wait;
    logic                     last;

    modport source (output valid, status, expired_id, next_wait, last, input ready);
    modport sink   (input valid, status, expired_id, next_wait, last, output ready);
endinterface

@@ rtl/tmhs_ctrl.sv @@
// ----------------------------------------------------------------------------
// tmhs_ctrl
// sequencer for add, cancel and poll words over the slot table
// ----------------------------------------------------------------------------
module tmhs_ctrl
    import tmhs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_PRD  = 3'd4;
    localparam logic [2:0] S_PUPD = 3'd5;
    localparam logic [2:0] S_ERD  = 3'd6;
    localparam logic [2:0] S_EOUT = 3'd7;

    logic [2:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec       = 1'b1;
                o_cmd.scan_start = 1'b1;
                o_cmd.scan_pick  = i_sts.pick_mode;
                n_state          = S_SCAN;
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (i_sts.in_pick && i_sts.found) begin
                    n_state = S_PRD;
                end else if (i_sts.in_pick) begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_SCAN;
                end else begin
                    n_state = S_ERD;
                end
            end
            S_PRD: begin
                o_cmd.pick_rd = 1'b1;
                n_state       = S_PUPD;
            end
            S_PUPD: begin
                o_cmd.pick_upd   = 1'b1;
                o_cmd.scan_start = 1'b1;
                o_cmd.scan_pick  = 1'b1;
                n_state          = S_SCAN;
            end
            S_ERD: begin
                o_cmd.emit_rd = 1'b1;
                n_state       = S_EOUT;
            end
            S_EOUT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_out = 1'b1;
                    n_state        = i_sts.emit_last ? S_IDLE : S_ERD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

@@ rtl/tmhs_dp.sv @@
// ----------------------------------------------------------------------------
// tmhs_dp
// slot table, scan compare, fired list and response register
// ----------------------------------------------------------------------------
module tmhs_dp
    import tmhs_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    output t_sts                     o_sts,
    input  logic [1:0]               i_action,
    input  logic [ID_W-1:0]          i_timer_id,
    input  logic [TIME_W-1:0]        i_now,
    input  logic [TIME_W-1:0]        i_period,
    input  logic [FIRE_W-1:0]        i_fire_count,
    input  logic                     i_out_ready,
    output logic                     o_out_valid,
    output logic [ST_W-1:0]          o_status,
    output logic [ID_W-1:0]          o_expired_id,
    output logic signed [WAIT_W-1:0] o_next_wait,
    output logic                     o_last
);

    t_entry            r_mem [SLOTS];
    logic [ID_W-1:0]   r_fired [SLOTS];

    logic [SLOTS-1:0]  r_valid, r_cancel, r_taken;
    logic [1:0]        r_action;
    logic [ID_W-1:0]   r_id;
    logic [TIME_W-1:0] r_now, r_period;
    logic [FIRE_W-1:0] r_fires;
    logic [ST_W-1:0]   r_st;

    logic [CNT_W-1:0]  r_cnt;
    logic              r_scanning, r_mode;
    logic              r_cmp_vld;
    logic [ID_W-1:0]   r_cmp_idx;
    t_entry            r_rd;
    logic              r_found;
    logic [TIME_W-1:0] r_best_exp;
    logic [ID_W-1:0]   r_best_idx;
    logic [CNT_W-1:0]  r_n, r_k;
    logic [ID_W-1:0]   r_fired_q;

    logic [ID_W-1:0]   rd_addr;
    logic              add_ok, cand, better, again;
    logic [TIME_W:0]   sum;
    t_entry            upd;
    logic [WAIT_W-1:0] wait_v;

    assign add_ok = (r_action == ACT_ADD) && !r_valid[r_id];
    assign rd_addr = i_cmd.pick_rd ? r_best_idx : r_cnt[ID_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && add_ok) begin
            r_mem[r_id] <= '{expiry: (({1'b0, r_now} + {1'b0, r_period}) > {1'b0, {TIME_W{1'b1}}})
                                     ? {TIME_W{1'b1}} : (r_now + r_period),
                            period: r_period, fires: r_fires};
        end else if (i_cmd.pick_upd && !r_cancel[r_best_idx] && again) begin
            r_mem[r_best_idx] <= upd;
        end
        r_rd <= r_mem[rd_addr];
    end

    assign sum = {1'b0, r_rd.expiry} + {1'b0, r_rd.period};
    assign again = (r_rd.fires != FIRE_W'(1));
    always_comb begin
        upd        = r_rd;
        upd.expiry = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
        upd.fires  = (r_rd.fires == '0) ? '0 : r_rd.fires - FIRE_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pick_upd && !r_cancel[r_best_idx]) begin
            r_fired[r_n[ID_W-1:0]] <= r_best_idx;
        end
        if (i_cmd.emit_rd) begin
            r_fired_q <= r_fired[r_k[ID_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_id     <= i_timer_id;
            r_now    <= i_now;
            r_period <= i_period;
            r_fires  <= i_fire_count;
        end
    end

    assign cand = r_mode ? (r_valid[r_cmp_idx] && !r_taken[r_cmp_idx] && (r_rd.expiry <= r_now))
                         : r_valid[r_cmp_idx];
    assign better = r_cmp_vld && cand && (!r_found || (r_rd.expiry < r_best_exp));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_cancel    <= '0;
            r_taken     <= '0;
            r_scanning  <= 1'b0;
            r_cmp_vld   <= 1'b0;
            r_found     <= 1'b0;
            r_mode      <= 1'b0;
            r_cnt       <= '0;
            r_n         <= '0;
            r_k         <= '0;
            r_st        <= ST_DONE;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                r_n     <= '0;
                r_k     <= '0;
                r_taken <= '0;
                unique case (r_action)
                    ACT_ADD: begin
                        if (r_valid[r_id]) begin
                            r_st <= ST_BUSY;
                        end else begin
                            r_st            <= ST_DONE;
                            r_valid[r_id]   <= 1'b1;
                            r_cancel[r_id]  <= 1'b0;
                        end
                    end
                    ACT_CANCEL: begin
                        if (r_valid[r_id]) begin
                            r_st           <= ST_DONE;
                            r_cancel[r_id] <= 1'b1;
                        end else begin
                            r_st <= ST_UNARMED;
                        end
                    end
                    ACT_POLL: r_st <= ST_NONE;
                    default:  r_st <= ST_DONE;
                endcase
            end
            if (i_cmd.pick_upd) begin
                r_taken[r_best_idx] <= 1'b1;
                if (r_cancel[r_best_idx]) begin
                    r_valid[r_best_idx]  <= 1'b0;
                    r_cancel[r_best_idx] <= 1'b0;
                end else begin
                    r_n <= r_n + CNT_W'(1);
                    if (!again) begin
                        r_valid[r_best_idx] <= 1'b0;
                    end
                end
            end
            if (i_cmd.scan_start) begin
                r_scanning <= 1'b1;
                r_cnt      <= '0;
                r_found    <= 1'b0;
                r_mode     <= i_cmd.scan_pick;
                r_cmp_vld  <= 1'b0;
            end else begin
                if (better) begin
                    r_found <= 1'b1;
                end
                if (r_scanning && (r_cnt < CNT_W'(SLOTS))) begin
                    r_cmp_vld <= 1'b1;
                    r_cmp_idx <= r_cnt[ID_W-1:0];
                    r_cnt     <= r_cnt + CNT_W'(1);
                end else begin
                    r_cmp_vld  <= 1'b0;
                    r_scanning <= 1'b0;
                end
            end
            if (i_cmd.emit_out) begin
                r_k <= r_k + CNT_W'(1);
            end
            if (i_cmd.emit_out) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (better) begin
            r_best_exp <= r_rd.expiry;
            r_best_idx <= r_cmp_idx;
        end
    end

    assign wait_v = !r_found ? {WAIT_W{1'b1}}
                  : (r_best_exp > r_now) ? {1'b0, r_best_exp - r_now} : '0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_out) begin
            o_next_wait <= $signed(wait_v);
            if (r_action == ACT_POLL && r_n != '0) begin
                o_status     <= ST_EXPIRED;
                o_expired_id <= r_fired_q;
                o_last       <= (r_k + CNT_W'(1) == r_n);
            end else begin
                o_status     <= r_st;
                o_expired_id <= '0;
                o_last       <= 1'b1;
            end
        end
    end

    always_comb begin
        o_sts.scan_done = r_cmp_vld && (r_cmp_idx == ID_W'(SLOTS - 1));
        o_sts.pick_mode = (r_action == ACT_POLL);
        o_sts.in_pick   = r_mode;
        o_sts.found     = r_found;
        o_sts.out_free  = !o_out_valid || i_out_ready;
        o_sts.emit_last = (r_action != ACT_POLL) || (r_n == '0) || (r_k + CNT_W'(1) == r_n);
    end

    a_fired_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= CNT_W'(SLOTS)) else $error("fired count overflow");
    a_cancel_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cancel & ~r_valid) == '0) else $error("cancel mark on free slot");
    a_pick_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pick_upd |-> !r_taken[r_best_idx] && r_valid[r_best_idx])
        else $error("slot picked twice in one poll");

endmodule

@@ rtl/timer_min_heap_scheduler_top.sv @@
// ----------------------------------------------------------------------------
// timer_min_heap_scheduler_top
// timer table with earliest-first expiry and next-wait report
// ----------------------------------------------------------------------------
// One word at a time. Add, cancel and no-op make one pass over the 64-slot
// table at one read a cycle. A poll that fires or frees k slots makes k + 2
// table passes, plus a read and an output state per emitted word, the output
// waiting while a word is held; the single read port of the slot table sets this.
module timer_min_heap_scheduler_top
    import tmhs_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    tmhs_req_if.sink      i_req,
    tmhs_rsp_if.source    o_rsp
);

    t_cmd cmd;
    t_sts sts;

    tmhs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .o_ready (i_req.ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    tmhs_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_action     (i_req.action),
        .i_timer_id   (i_req.timer_id),
        .i_now        (i_req.now),
        .i_period     (i_req.period),
        .i_fire_count (i_req.fire_count),
        .i_out_ready  (o_rsp.ready),
        .o_out_valid  (o_rsp.valid),
        .o_status     (o_rsp.status),
        .o_expired_id (o_rsp.expired_id),
        .o_next_wait  (o_rsp.next_wait),
        .o_last       (o_rsp.last)
    );

endmodule

@@ tb/sv/tb_timer_sched_pkg.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_timer_sched_pkg
// expected-word store and timer table predictor for the scheduler bench
// ----------------------------------------------------------------------------
package tb_timer_sched_pkg;
    import tmhs_pkg::*;

    typedef struct packed {
        logic [ST_W-1:0]          status;
        logic [ID_W-1:0]          expired_id;
        logic signed [WAIT_W-1:0] next_wait;
        logic                     last;
    } t_rsp_word;

    class timer_table_sb;
        bit                slot_armed [SLOTS];
        bit                slot_marked[SLOTS];
        logic [TIME_W-1:0] slot_expiry[SLOTS];
        logic [TIME_W-1:0] slot_period[SLOTS];
        logic [FIRE_W-1:0] slot_fires [SLOTS];
        t_rsp_word         pending_words[$];
        int                n_errors;
        int                n_fired;
        int                n_checked;

        function void clear();
            foreach (slot_armed[i]) begin
                slot_armed[i]  = 0;
                slot_marked[i] = 0;
                slot_expiry[i] = '0;
                slot_period[i] = '0;
                slot_fires[i]  = '0;
            end
        endfunction

        function logic [TIME_W-1:0] sat_sum(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
            logic [TIME_W:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[TIME_W] ? '1 : s[TIME_W-1:0];
        endfunction

        function logic [WAIT_W-1:0] wait_after(logic [TIME_W-1:0] now);
            bit                any;
            logic [TIME_W-1:0] best;
            any  = 0;
            best = '0;
            for (int i = 0; i < SLOTS; i++)
                if (slot_armed[i] && (!any || slot_expiry[i] < best)) begin
                    best = slot_expiry[i];
                    any  = 1;
                end
            if (!any) return '1;
            return best > now ? {1'b0, best - now} : '0;
        endfunction

        function void push(logic [ST_W-1:0] st, int id, logic [WAIT_W-1:0] w, bit lst);
            t_rsp_word x;
            x.status     = st;
            x.expired_id = id[ID_W-1:0];
            x.next_wait  = w;
            x.last       = lst;
            pending_words.insert(pending_words.size(), x);
        endfunction

        function void note_request(logic [1:0] act, logic [ID_W-1:0] id,
                                   logic [TIME_W-1:0] now, logic [TIME_W-1:0] per,
                                   logic [FIRE_W-1:0] cnt);
            logic [ST_W-1:0] st;
            bit              taken[SLOTS];
            int              fired[$];
            int              pick;
            bit              again;
            logic [WAIT_W-1:0] w;
            st = ST_DONE;
            if (act == ACT_ADD) begin
                if (slot_armed[id]) st = ST_BUSY;
                else begin
                    slot_armed[id]  = 1;
                    slot_marked[id] = 0;
                    slot_expiry[id] = sat_sum(now, per);
                    slot_period[id] = per;
                    slot_fires[id]  = cnt;
                end
                push(st, 0, wait_after(now), 1);
            end else if (act == ACT_CANCEL) begin
                if (!slot_armed[id]) st = ST_UNARMED;
                else slot_marked[id] = 1;
                push(st, 0, wait_after(now), 1);
            end else if (act == ACT_POLL) begin
                foreach (taken[i]) taken[i] = 0;
                while (fired.size() < SLOTS) begin
                    pick = -1;
                    for (int i = 0; i < SLOTS; i++)
                        if (slot_armed[i] && !taken[i] && slot_expiry[i] <= now &&
                            (pick < 0 || slot_expiry[i] < slot_expiry[pick]))
                            pick = i;
                    if (pick < 0) break;
                    taken[pick] = 1;
                    if (slot_marked[pick]) begin
                        slot_armed[pick]  = 0;
                        slot_marked[pick] = 0;
                    end else fired.insert(fired.size(), pick);
                end
                foreach (fired[k]) begin
                    again = 1;
                    if (slot_fires[fired[k]] != 0) begin
                        slot_fires[fired[k]]--;
                        if (slot_fires[fired[k]] == 0) again = 0;
                    end
                    if (again)
                        slot_expiry[fired[k]] = sat_sum(slot_expiry[fired[k]],
                                                        slot_period[fired[k]]);
                    else slot_armed[fired[k]] = 0;
                end
                w = wait_after(now);
                if (fired.size() == 0) push(ST_NONE, 0, w, 1);
                foreach (fired[k]) push(ST_EXPIRED, fired[k], w, k == fired.size() - 1);
                n_fired += fired.size();
            end else
                push(ST_DONE, 0, wait_after(now), 1);
        endfunction

        function void check_word(t_rsp_word got);
            t_rsp_word e;
            n_checked++;
            if (pending_words.size() == 0) begin
                $error("unexpected word status=%0d id=%0d", got.status, got.expired_id);
                n_errors++;
                return;
            end
            e = pending_words.pop_front();
            if (got.status !== e.status) begin
                $error("status: expected %0d, got %0d", e.status, got.status);
                n_errors++;
            end
            if (got.expired_id !== e.expired_id) begin
                $error("expired_id: expected %0d, got %0d", e.expired_id, got.expired_id);
                n_errors++;
            end
            if (got.next_wait !== e.next_wait) begin
                $error("next_wait: expected %0d, got %0d", e.next_wait, got.next_wait);
                n_errors++;
            end
            if (got.last !== e.last) begin
                $error("last: expected %0d, got %0d", e.last, got.last);
                n_errors++;
            end
        endfunction
    endclass

endpackage

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// random and directed test of the timer table scheduler
// ----------------------------------------------------------------------------
// Adds, cancels, polls and no-ops are driven on the request channel; each
// accepted word is fed to a table predictor and every response word is
// compared with the oldest prediction, under varying idle and stall phases.
// ----------------------------------------------------------------------------
module tb_top;
    import tmhs_pkg::*;
    import tb_timer_sched_pkg::*;

    localparam int STALL_LIMIT = 200000;
    localparam logic [1:0] ACT_NOP = 2'd3;

    logic i_clk = 0;
    logic i_rst_n = 0;
    tmhs_req_if req_if();
    tmhs_rsp_if rsp_if();

    timer_min_heap_scheduler_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req_if.sink), .o_rsp(rsp_if.source));

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    timer_table_sb sb = new();
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  hold_off = 0;
    int  idle_cycles = 0;
    int  n_sent = 0;
    logic [TIME_W-1:0] tick = '0;

    initial begin
        req_if.valid = 0; req_if.action = ACT_NOP; req_if.timer_id = '0;
        req_if.now = '0; req_if.period = '0; req_if.fire_count = '0;
        rsp_if.ready = 0;
    end

    always @(posedge i_clk) begin
        if (req_if.valid && req_if.ready)
            sb.note_request(req_if.action, req_if.timer_id, req_if.now,
                            req_if.period, req_if.fire_count);
        if (rsp_if.valid && rsp_if.ready)
            sb.check_word({rsp_if.status, rsp_if.expired_id, rsp_if.next_wait, rsp_if.last});
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("timer_min_heap_scheduler_top test failed");
            $finish;
        end
        rsp_if.ready <= i_rst_n && !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_word(logic [1:0] act, logic [ID_W-1:0] id, logic [TIME_W-1:0] now,
                             logic [TIME_W-1:0] per, logic [FIRE_W-1:0] cnt);
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 0;
            @(posedge i_clk);
        end
        req_if.valid <= 1; req_if.action <= act; req_if.timer_id <= id;
        req_if.now <= now; req_if.period <= per; req_if.fire_count <= cnt;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        n_sent++;
    endtask

    task automatic finish_words();
        req_if.valid <= 0;
        @(posedge i_clk);
        while (sb.pending_words.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    // mostly short periods so polls find expiries; time only moves forward
    task automatic random_word();
        int r;
        logic [TIME_W-1:0] per;
        r = $urandom_range(99);
        per = ($urandom_range(9) == 0) ? $urandom : $urandom_range(40);
        if (r < 40)
            send_word(ACT_ADD, ID_W'($urandom), tick, per,
                      FIRE_W'(($urandom_range(3) == 0) ? $urandom : $urandom_range(3)));
        else if (r < 55)
            send_word(ACT_CANCEL, ID_W'($urandom), tick, $urandom, FIRE_W'($urandom));
        else if (r < 95) begin
            tick = tick + TIME_W'($urandom_range(30));
            send_word(ACT_POLL, ID_W'($urandom), tick, $urandom, FIRE_W'($urandom));
        end else
            send_word(ACT_NOP, ID_W'($urandom), tick, $urandom, FIRE_W'($urandom));
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: empty poll, zero period, busy, cancel cases, extremes
        send_word(ACT_POLL, 6'd0, 32'd0, 32'd0, 8'd0);
        send_word(ACT_CANCEL, 6'd63, 32'd0, 32'd0, 8'd0);
        send_word(ACT_ADD, 6'd0, 32'd10, 32'd0, 8'd2);
        send_word(ACT_ADD, 6'd0, 32'd10, 32'd5, 8'd1);
        send_word(ACT_ADD, 6'd63, 32'd10, 32'hFFFF_FFFF, 8'hFF);
        send_word(ACT_ADD, 6'd5, 32'd10, 32'd3, 8'd0);
        send_word(ACT_ADD, 6'd4, 32'd10, 32'd3, 8'd0);
        send_word(ACT_CANCEL, 6'd4, 32'd11, 32'd0, 8'd0);
        send_word(ACT_CANCEL, 6'd4, 32'd11, 32'd0, 8'd0);
        send_word(ACT_NOP, 6'd0, 32'd12, 32'd0, 8'd0);
        send_word(ACT_POLL, 6'd0, 32'd10, 32'd0, 8'd0);
        send_word(ACT_POLL, 6'd0, 32'd10, 32'd0, 8'd0);
        send_word(ACT_POLL, 6'd0, 32'd13, 32'd0, 8'd0);
        send_word(ACT_POLL, 6'd0, 32'hFFFF_FFFF, 32'd0, 8'd0);
        send_word(ACT_POLL, 6'd0, 32'hFFFF_FFFF, 32'd0, 8'd0);
        // an add for every slot at one expiry time: a burst of expiries
        for (int i = 0; i < SLOTS; i++) send_word(ACT_ADD, ID_W'(i), 32'd100, 32'd1, 8'd1);
        send_word(ACT_POLL, 6'd0, 32'd200, 32'd0, 8'd0);
        finish_words();

        // no pauses, sender pauses, receiver hold-off with stalls, then both mixed
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1 || ph == 3) ? 76 : (ph == 3 ? 32 : 0);
            recv_stall_pct = (ph == 2) ? 76 : 0;
            if (ph == 3) begin send_idle_pct = 32; recv_stall_pct = 32; end
            if (ph == 2) begin
                hold_off = 1;
                fork
                    begin repeat (3000) @(posedge i_clk); hold_off = 0; end
                join_none
            end
            for (int k = 0; k < 32; k++) random_word();
            finish_words();
        end
        send_idle_pct = 0; recv_stall_pct = 0;

        $display("sent %0d request words, checked %0d response words, %0d expiries",
                 n_sent, sb.n_checked, sb.n_fired);
        if (sb.n_errors == 0 && sb.pending_words.size() == 0)
            $display("timer_min_heap_scheduler_top test passed");
        else
            $display("timer_min_heap_scheduler_top test failed");
        $finish;
    end

endmodule

@@ files.f @@
rtl/tmhs_pkg.sv
rtl/tmhs_if.sv
rtl/tmhs_ctrl.sv
rtl/tmhs_dp.sv
rtl/timer_min_heap_scheduler_top.sv
tb/sv/tb_timer_sched_pkg.sv
tb/sv/tb_top.sv
